// File: rtl/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/hpa_pkg.sv
// types and constants for the half-precision adder
// no dependencies
package hpa_pkg;

  localparam logic [15:0] SIGN_MASK  = 16'h8000;
  localparam logic [15:0] POS_INF    = 16'h7C00;
  localparam logic [15:0] NEG_INF    = 16'hFC00;
  localparam logic [15:0] CANON_NAN  = 16'h7C01;
  localparam logic [4:0]  EXP_ONES   = 5'b11111;

  typedef logic [15:0] hp_t;

  // stage 1 -> 2: unpacked and aligned operands
  typedef struct packed {
    logic        special;
    hp_t         special_val;
    logic        sa;
    logic        sb;
    logic [4:0]  exp;
    logic [10:0] fa;
    logic [10:0] fb;
  } hpa_align_t;

  // stage 2 -> 3: raw sum or difference
  typedef struct packed {
    logic        special;
    hp_t         special_val;
    logic        sign;
    logic        sub;
    logic [4:0]  exp;
    logic [11:0] mag;
  } hpa_sum_t;

endpackage

// File: rtl/hpa_if.sv
// valid/ready channel carrying a pair of operands or a result
// depends on hpa_pkg
interface hpa_in_if;
  logic          valid;
  logic          ready;
  hpa_pkg::hp_t  operand_a;
  hpa_pkg::hp_t  operand_b;
  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface hpa_out_if;
  logic          valid;
  logic          ready;
  hpa_pkg::hp_t  sum_bits;
  modport source (output valid, output sum_bits, input ready);
  modport sink   (input valid, input sum_bits, output ready);
endinterface

// File: rtl/half_precision_adder.sv
// top level of the half-precision adder: three-stage pipeline
// depends on hpa_pkg, hpa_if, hpa_align, hpa_addsub, hpa_norm, assert_macros.svh
// Adds two binary16 operands with truncation (no rounding). Fully pipelined:
// one transaction enters per cycle unless an output stall backs up to the input;
// its result is registered in the align, add/subtract and normalize stages. A
// stall on the output holds every stage that is occupied; a bubble is filled
// while the output waits. NaN results are always 0x7C01; underflow flushes to +0.
`include "assert_macros.svh"
module half_precision_adder (
  input  logic   clk,
  input  logic   rst_n,
  hpa_in_if.sink   in_ch,
  hpa_out_if.source out_ch
);
  import hpa_pkg::*;

  hpa_align_t s1_nxt, s1_r;
  hpa_sum_t   s2_nxt, s2_r;
  hp_t        s3_nxt, s3_r;
  logic       v1_r, v2_r, v3_r;
  logic       en1, en2, en3;

  hpa_align  u_align  (.a(in_ch.operand_a), .b(in_ch.operand_b), .res(s1_nxt));
  hpa_addsub u_addsub (.op(s1_r), .res(s2_nxt));
  hpa_norm   u_norm   (.op(s2_r), .res(s3_nxt));

  assign en3 = !v3_r || out_ch.ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1;
  assign out_ch.valid = v3_r;
  assign out_ch.sum_bits = s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1_r <= s1_nxt;
    if (en2) s2_r <= s2_nxt;
    if (en3) s3_r <= s3_nxt;
  end

  `ASSERT_NEXT(a_stall_hold, clk, rst_n, v3_r && !out_ch.ready, v3_r && $stable(s3_r))
  `ASSERT_IMPL(a_ready_free, clk, rst_n, !v1_r, in_ch.ready)
  `ASSERT_NEXT(a_advance, clk, rst_n, v2_r && en3, v3_r)
endmodule

// File: rtl/hpa_align.sv
// stage 1 logic: special-case detection, hidden bits, exponent alignment
// depends on hpa_pkg
module hpa_align (
  input  hpa_pkg::hp_t       a,
  input  hpa_pkg::hp_t       b,
  output hpa_pkg::hpa_align_t res
);
  import hpa_pkg::*;

  logic [4:0]  ea, eb;
  logic [9:0]  fa, fb;
  logic        nan_a, nan_b, inf_a, inf_b;
  logic [10:0] ma, mb;
  logic [4:0]  diff_ab, diff_ba;

  always_comb begin
    ea = a[14:10];
    eb = b[14:10];
    fa = a[9:0];
    fb = b[9:0];
    nan_a = (ea == EXP_ONES) && (fa != '0);
    nan_b = (eb == EXP_ONES) && (fb != '0);
    inf_a = (ea == EXP_ONES) && (fa == '0);
    inf_b = (eb == EXP_ONES) && (fb == '0);
    ma = {(ea != '0), fa};
    mb = {(eb != '0), fb};
    diff_ab = ea - eb;
    diff_ba = eb - ea;

    res.special     = nan_a || nan_b || inf_a || inf_b;
    res.special_val = CANON_NAN;
    if (nan_a || nan_b)
      res.special_val = CANON_NAN;
    else if (inf_a && inf_b)
      res.special_val = (a[15] == b[15]) ? (a[15] ? NEG_INF : POS_INF) : CANON_NAN;
    else if (inf_a)
      res.special_val = a[15] ? NEG_INF : POS_INF;
    else if (inf_b)
      res.special_val = b[15] ? NEG_INF : POS_INF;

    res.sa = a[15];
    res.sb = b[15];
    if (ea > eb) begin
      res.exp = ea;
      res.fa  = ma;
      res.fb  = mb >> diff_ab;
    end else begin
      res.exp = eb;
      res.fa  = ma >> diff_ba;
      res.fb  = mb;
    end
  end
endmodule

// File: rtl/hpa_addsub.sv
// stage 2 logic: magnitude add or subtract with sign selection
// depends on hpa_pkg
module hpa_addsub (
  input  hpa_pkg::hpa_align_t op,
  output hpa_pkg::hpa_sum_t   res
);
  import hpa_pkg::*;

  always_comb begin
    res.special     = op.special;
    res.special_val = op.special_val;
    res.exp         = op.exp;
    res.sub         = (op.sa != op.sb);
    if (op.sa == op.sb) begin
      res.sign = op.sa;
      res.mag  = {1'b0, op.fa} + {1'b0, op.fb};
    end else if (op.fa > op.fb) begin
      res.sign = op.sa;
      res.mag  = {1'b0, op.fa - op.fb};
    end else begin
      res.sign = op.sb;
      res.mag  = {1'b0, op.fb - op.fa};
    end
  end
endmodule

// File: rtl/hpa_norm.sv
// stage 3 logic: carry handling, leading-zero normalization, packing
// depends on hpa_pkg
module hpa_norm (
  input  hpa_pkg::hpa_sum_t op,
  output hpa_pkg::hp_t      res
);
  import hpa_pkg::*;

  logic [3:0]  lz;
  logic [10:0] shifted;
  logic [5:0]  e;
  logic [9:0]  frac;
  logic        found;

  always_comb begin
    lz    = '0;
    found = 1'b0;
    for (int i = 10; i >= 0; i--) begin
      if (!found && op.mag[i]) begin
        found = 1'b1;
        lz    = 4'(10 - i);
      end
    end
    shifted = op.mag[10:0] << lz;
    e       = {1'b0, op.exp};
    frac    = op.mag[9:0];
    res     = '0;

    if (op.special) begin
      res = op.special_val;
    end else if (!op.sub) begin
      if (op.mag[11]) begin
        e    = e + 6'd1;
        frac = op.mag[10:1];
      end else if (op.exp == '0 && op.mag[10]) begin
        e = 6'd1;
      end
      if (e >= 6'd31)
        res = op.sign ? NEG_INF : POS_INF;
      else
        res = {op.sign, e[4:0], frac};
    end else begin
      // zero difference or exponent underflow flushes to +0
      if (op.mag == '0 || {2'b0, lz} >= e)
        res = '0;
      else
        res = {op.sign, 5'(e - {2'b0, lz}), shifted[9:0]};
    end
  end
endmodule
